FILE: sv/pepsd_pkg.sv
// Shared types, constants and helpers for the packed-exponent sample converter.
// No dependencies; used by packed_exponent_sample_to_double and its testbench.
package pepsd_pkg;

    localparam int MANT_W   = 24;
    localparam int EXPIN_W  = 7;
    localparam int SIG_W    = 53;
    localparam int PROD_W   = MANT_W + SIG_W;   // 77-bit exact product
    localparam int LZ_W     = 7;
    localparam int EXP_W    = 13;               // signed working exponent
    localparam int SH_W     = 8;

    localparam logic [63:0] SCALE_RESET   = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN   = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT     = 64'h0008_0000_0000_0000;
    localparam logic [10:0] EXP_ALL_ONES  = 11'h7FF;
    // ex - 88 + (E - 1075), and ex - 88 - 1074 for subnormal scale
    localparam logic [EXP_W-1:0] EOFS_NORM = 13'd1163;
    localparam logic [EXP_W-1:0] EOFS_SUB  = 13'd1162;
    // biased result exponent = e0 - lz + 76 + 1023
    localparam logic [EXP_W-1:0] R_OFS     = 13'd1099;

    // Per-item side information that travels with the datapath
    typedef struct packed {
        logic        sgn;
        logic        spec;
        logic        zero;
        logic [63:0] spec_val;
    } side_t;

    // Leading-zero count of the product (value for zero is unused)
    function automatic logic [LZ_W-1:0] lzc(input logic [PROD_W-1:0] v);
        logic [LZ_W-1:0] n;
        n = '0;
        for (int i = 0; i < PROD_W; i++)
        begin
            if (v[i])
                n = LZ_W'(PROD_W - 1 - i);
        end
        return n;
    endfunction

endpackage

FILE: sv/packed_exponent_sample_to_double.sv
// Packed-exponent sample to IEEE double converter, seven-stage pipeline.
// Throughput one beat per cycle while the output beat is not stalled.
// The whole pipe advances together and holds while the output beat is stalled.
// rst_n (asynchronous, active low) clears all valid bits and loads scale 1.0.
// Depends on pepsd_pkg.
module packed_exponent_sample_to_double
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // [31:0] raw_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,      // [63:0] sample_value
    input  logic        scale_we,
    input  logic [63:0] scale_wdata
);

    localparam int NST = 7;
    localparam int PW  = pepsd_pkg::PROD_W;

    logic                            adv;
    logic [NST-1:0]                  vld_reg;
    logic [63:0]                     scale_reg;
    pepsd_pkg::side_t                sd_reg [NST-2:0];

    // decode fields
    logic [23:0]                     mant;
    logic [6:0]                      ex;
    logic [10:0]                     se;
    logic [51:0]                     sf;
    logic [52:0]                     sig;
    logic                            s_nan, s_inf;
    pepsd_pkg::side_t                sd_next;
    logic [pepsd_pkg::EXP_W-1:0]     e0_next;

    // stage registers
    logic [55:0]                     pl_reg;     // mant * sig[31:0]
    logic [44:0]                     ph_reg;     // mant * sig[52:32]
    logic [pepsd_pkg::EXP_W-1:0]     e0_reg [2:0];
    logic [PW-1:0]                   p2_reg, p3_reg, n4_reg, n5_reg;
    logic [pepsd_pkg::LZ_W-1:0]      lz_reg;
    logic [pepsd_pkg::EXP_W-1:0]     r4_reg;
    logic [pepsd_pkg::SH_W-1:0]      sh_reg;
    logic [10:0]                     ef5_reg, ef6_reg;
    logic                            ovf5_reg, ovf6_reg;
    logic [52:0]                     q_reg;
    logic                            g_reg, st_reg;
    logic [63:0]                     out_reg;

    logic [PW-1:0]                   d6;
    logic [pepsd_pkg::EXP_W-1:0]     neg_r;
    logic                            rup;
    logic [62:0]                     mag;
    logic [63:0]                     res;

    assign adv      = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = out_reg;

    // Hold the scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= pepsd_pkg::SCALE_RESET;
        else if (scale_we)
            scale_reg <= scale_wdata;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
    end

    // Decode the beat and the scale, pick out special results
    always_comb
    begin
        mant  = s_tdata[23:0];
        ex    = s_tdata[30:24];
        se    = scale_reg[62:52];
        sf    = scale_reg[51:0];
        sig   = {(se != 11'd0), sf};
        s_nan = (se == pepsd_pkg::EXP_ALL_ONES) && (sf != 52'd0);
        s_inf = (se == pepsd_pkg::EXP_ALL_ONES) && (sf == 52'd0);
        sd_next.sgn      = scale_reg[63];
        sd_next.zero     = (mant == 24'd0) || (scale_reg[62:0] == 63'd0);
        sd_next.spec     = s_nan || s_inf;
        if (s_nan)
            sd_next.spec_val = scale_reg | pepsd_pkg::QUIET_BIT;
        else if (mant == 24'd0)
            sd_next.spec_val = pepsd_pkg::DEFAULT_NAN;
        else
            sd_next.spec_val = {scale_reg[63], pepsd_pkg::EXP_ALL_ONES, 52'd0};
        if (se == 11'd0)
            e0_next = pepsd_pkg::EXP_W'(ex) - pepsd_pkg::EOFS_SUB;
        else
            e0_next = pepsd_pkg::EXP_W'(ex) + pepsd_pkg::EXP_W'(se) - pepsd_pkg::EOFS_NORM;
    end

    // Side information pipe
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= sd_next;
            for (int i = 1; i < NST-1; i++)
                sd_reg[i] <= sd_reg[i-1];
        end
    end

    // Compute the denormalizing shift, rounding bits and result
    always_comb
    begin
        d6    = n5_reg >> sh_reg;
        neg_r = pepsd_pkg::EXP_W'(1) - r4_reg;
        rup   = g_reg && (st_reg || q_reg[0]);
        mag   = {ef6_reg, 52'd0} + 63'(q_reg) + 63'(rup);
        if (sd_reg[NST-2].spec)
            res = sd_reg[NST-2].spec_val;
        else if (sd_reg[NST-2].zero)
            res = {sd_reg[NST-2].sgn, 63'd0};
        else if (ovf6_reg)
            res = {sd_reg[NST-2].sgn, pepsd_pkg::EXP_ALL_ONES, 52'd0};
        else
            res = {sd_reg[NST-2].sgn, mag};
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // partial products
            pl_reg    <= mant * sig[31:0];
            ph_reg    <= mant * sig[52:32];
            e0_reg[0] <= e0_next;
            // exact product
            p2_reg    <= {ph_reg, 32'd0} + PW'(pl_reg);
            e0_reg[1] <= e0_reg[0];
            // leading-zero count
            p3_reg    <= p2_reg;
            lz_reg    <= pepsd_pkg::lzc(p2_reg);
            e0_reg[2] <= e0_reg[1];
            // normalize
            n4_reg    <= p3_reg << lz_reg;
            r4_reg    <= e0_reg[2] + pepsd_pkg::R_OFS - pepsd_pkg::EXP_W'(lz_reg);
            // exponent field and subnormal shift
            n5_reg    <= n4_reg;
            if (!r4_reg[pepsd_pkg::EXP_W-1] && (r4_reg != '0))
            begin
                sh_reg   <= '0;
                ef5_reg  <= 11'(r4_reg - pepsd_pkg::EXP_W'(1));
                ovf5_reg <= (r4_reg >= pepsd_pkg::EXP_W'(2047));
            end
            else
            begin
                sh_reg   <= neg_r[pepsd_pkg::SH_W-1:0];
                ef5_reg  <= '0;
                ovf5_reg <= 1'b0;
            end
            // denormalize, gather guard and sticky
            q_reg    <= d6[PW-1:24];
            g_reg    <= d6[23];
            st_reg   <= (|d6[22:0]) || ((d6 << sh_reg) != n5_reg);
            ef6_reg  <= ef5_reg;
            ovf6_reg <= ovf5_reg;
            // round and pack
            out_reg  <= res;
        end
    end

endmodule

FILE: sv/pepsd_checker.sv
// Port-level checker for packed_exponent_sample_to_double, bound to the top level.
// Depends only on the top-level ports.
module pepsd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // Stalled output beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // Input is taken whenever the output can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // No output right after reset
    a_rst: assert property (@(posedge clk)
        !$past(rst_n) |-> !m_tvalid)
        else $error("output beat right after reset");

    // Any NaN produced is quiet
    a_qnan: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[62:52] == 11'h7FF) && (m_tdata[51:0] != 52'd0) |-> m_tdata[51])
        else $error("signaling NaN on output");

endmodule

bind packed_exponent_sample_to_double pepsd_checker u_pepsd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: test/tb_packed_exponent_sample_to_double.sv
// Testbench for packed_exponent_sample_to_double: random and directed raw words,
// predicted with native double arithmetic and checked beat by beat.
// Depends on pepsd_pkg and the RTL of packed_exponent_sample_to_double.
`timescale 1ns / 1ps

module tb_packed_exponent_sample_to_double;

    localparam int        CYCLE_LIMIT = 400000;
    localparam int        PIPE_LAT    = 7;
    localparam logic [63:0] EXP_FIELD  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] FRAC_FIELD = 64'h000F_FFFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        scale_we;
    logic [63:0] scale_wdata;

    logic [31:0] raw_words[$];
    logic [63:0] expected_values[$];
    logic [63:0] cur_scale;
    int          fail_count;
    int          cycle_count;
    int          tx_gap_max;
    int          tx_wait;
    int          rx_gap_max;
    int          rx_wait;
    int          rx_hold;
    bit          hold_req;
    bit          in_beat;
    bit          out_beat;

    packed_exponent_sample_to_double i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .scale_we    (scale_we),
        .scale_wdata (scale_wdata)
    );

    // Decode the packed word and scale it; NaN cases follow the block's rules
    function automatic logic [63:0] scaled_sample(input logic [31:0] word,
                                                  input logic [63:0] scale);
        logic [23:0] mant;
        logic [6:0]  ex;
        logic [10:0] pexp;
        real         val;
        mant = word[23:0];
        ex   = word[30:24];
        if ((scale & EXP_FIELD) == EXP_FIELD && (scale & FRAC_FIELD) != 0)
            return scale | pepsd_pkg::QUIET_BIT;
        if (mant == 0 && (scale & EXP_FIELD) == EXP_FIELD)
            return pepsd_pkg::DEFAULT_NAN;
        pexp = 11'(ex) + 11'd935;
        val  = real'(mant) * $bitstoreal({1'b0, pexp, 52'b0});
        return $realtobits(val * $bitstoreal(scale));
    endfunction

    // Random word: mostly full range, some zero or tiny mantissas or extreme exponents
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0: w[23:0] = '0;
            1: w[23:0] = 24'($urandom_range(1, 3));
            2: w[30:24] = $urandom_range(0, 1) ? 7'h7F : 7'h00;
            default: ;
        endcase
        return w;
    endfunction

    // Random scale: exponent biased toward the extremes to reach overflow/underflow
    function automatic logic [63:0] rand_scale();
        logic [63:0] s;
        s = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: s[62:52] = 11'($urandom_range(0, 60));
            1: s[62:52] = 11'($urandom_range(1960, 2046));
            2: s[62:52] = 11'($urandom_range(900, 1150));
            default: ;
        endcase
        return s;
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Monitor: record input beats, check output beats
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_values.push_back(scaled_sample(s_tdata, cur_scale));
            in_beat = 1'b1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            out_beat = 1'b1;
            if (expected_values.size() == 0)
            begin
                $error("sample_value: unexpected beat, actual %h", m_tdata);
                fail_count++;
            end
            else
            begin
                logic [63:0] exp_val;
                exp_val = expected_values.pop_front();
                if (m_tdata !== exp_val)
                begin
                    $error("sample_value: expected %h, actual %h", exp_val, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Driver: hold a beat until accepted, then wait a drawn gap
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_beat))
        begin
            if (in_beat)
            begin
                in_beat = 1'b0;
                tx_wait = $urandom_range(0, tx_gap_max);
            end
            if (tx_wait > 0)
            begin
                tx_wait--;
                s_tvalid <= 1'b0;
            end
            else if (raw_words.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= raw_words.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: per-beat stall, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            rx_hold  = 200;
        end
        if (out_beat)
        begin
            out_beat = 1'b0;
            rx_wait  = $urandom_range(0, rx_gap_max);
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Wait until every queued word has gone through and the pipe has drained
    task automatic drain();
        while (raw_words.size() > 0 || s_tvalid || expected_values.size() > 0)
            @(posedge clk);
        repeat (PIPE_LAT + 5) @(posedge clk);
    endtask

    task automatic write_scale(input logic [63:0] value);
        @(negedge clk);
        scale_we    <= 1'b1;
        scale_wdata <= value;
        @(negedge clk);
        scale_we    <= 1'b0;
        cur_scale    = value;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            raw_words.push_back(rand_word());
        drain();
    endtask

    initial
    begin
        logic [63:0] fixed_scales[$];
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        scale_we    = 1'b0;
        scale_wdata = '0;
        cur_scale   = pepsd_pkg::SCALE_RESET;
        fail_count  = 0;
        cycle_count = 0;
        tx_gap_max  = 3;
        rx_gap_max  = 3;
        tx_wait     = 0;
        rx_wait     = 0;
        rx_hold     = 0;
        hold_req    = 1'b0;
        in_beat     = 1'b0;
        out_beat    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes with the reset scale of 1.0
        raw_words.push_back(32'h0000_0000);
        raw_words.push_back(32'h00FF_FFFF);
        raw_words.push_back(32'h7FFF_FFFF);
        raw_words.push_back(32'h7F00_0001);
        raw_words.push_back(32'h0000_0001);
        raw_words.push_back(32'h8000_0001);
        raw_words.push_back(32'hFFFF_FFFF);
        raw_words.push_back(32'h5800_0001);
        raw_words.push_back(32'h7F00_0000);
        raw_words.push_back(32'h80AA_5555);
        raw_words.push_back(32'h2A55_AAAA);
        drain();

        // Special scales: zeros, infinities, NaNs, extremes
        fixed_scales = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                         64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                         64'h7FF0_0000_0000_0001, 64'hFFF8_1234_5678_9ABC,
                         64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                         64'hFFFF_FFFF_FFFF_FFFF, 64'h000F_FFFF_FFFF_FFFF};
        foreach (fixed_scales[k])
        begin
            write_scale(fixed_scales[k]);
            raw_words.push_back(32'h0000_0000);
            raw_words.push_back(32'hFFFF_FFFF);
            raw_words.push_back(32'h0000_0001);
            run_random(40);
        end

        // Back-to-back traffic into a long output stall to fill the pipe
        write_scale(64'h3EAA_D7F2_9ABC_AF48);
        tx_gap_max = 0;
        rx_gap_max = 0;
        hold_req   = 1'b1;
        run_random(120);

        // Random scales with random idling on both sides
        for (int p = 0; p < 16; p++)
        begin
            write_scale(rand_scale());
            tx_gap_max = (p % 4 == 0) ? 0 : 15;
            rx_gap_max = (p % 4 == 1) ? 0 : 15;
            run_random(45);
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
